[rtl/insertion_sorter_assert.svh]
// Assertion helpers shared by the checker files.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

// Property must hold at every edge outside reset.
`define INS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Trigger at one edge requires the consequence at the next edge.
`define INS_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ins_sort_pkg.sv]
`default_nettype none
package ins_sort_pkg;

  localparam int unsigned ValueW = 32;

  typedef logic signed [ValueW-1:0] value_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // insert key_i at its sorted place
    logic shift;  // move contents one cell toward cell 0
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/ins_sort_cell.sv]
`default_nettype none
module ins_sort_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ins_sort_pkg::cell_ctrl_t ctrl_i,
  input  wire ins_sort_pkg::value_t    key_i,
  input  wire ins_sort_pkg::value_t    below_key_i,
  input  wire logic                    below_gt_i,
  input  wire logic                    below_valid_i,
  input  wire ins_sort_pkg::value_t    above_key_i,
  input  wire logic                    above_valid_i,
  output ins_sort_pkg::value_t         key_o,
  output logic                         valid_o,
  output logic                         gt_o
);

  ins_sort_pkg::value_t key_q, key_d;
  logic                 valid_q, valid_d;
  logic                 gt;

  // empty cells count as larger than anything
  assign gt = !valid_q || (key_q > key_i);

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      key_d   = above_key_i;
      valid_d = above_valid_i;
    end else if (ctrl_i.ins) begin
      valid_d = valid_q | below_valid_i;
      if (gt) begin
        key_d = below_gt_i ? below_key_i : key_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;
  assign gt_o    = gt;

endmodule
`default_nettype wire

[rtl/insertion_sorter.sv]
`default_nettype none
// Streaming insertion sorter for signed 32-bit values. Each input transaction
// carries one value; it is placed into a row of MAX_ITEMS compare-and-shift
// cells when accepted, every cell holding one entry and comparing it against
// the broadcast value, strictly larger entries moving up one cell so equal
// values keep arrival order. Collection runs at one transaction per cycle.
// The transaction with tlast set is inserted too (if a cell is free) and then
// starts emission: while the output register is free the row shifts toward
// cell 0 once per cycle, cell 0 feeding the output register, so a set drains
// smallest first, the final result with tlast set. While a set drains
// s_axis_tready_o is low; it rises again the cycle the largest value
// enters the output register. Values arriving while all cells are full are
// dropped and every result of that set shows overflow in m_axis_tuser_o.
module insertion_sorter #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic        s_axis_tlast_i,   // last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] value_res
  output logic             m_axis_tlast_o,   // last_res
  output logic             m_axis_tuser_o    // [0] overflow
);

  ins_sort_pkg::value_t     key_in;
  ins_sort_pkg::value_t     cell_key [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]     cell_valid;
  logic [MAX_ITEMS-1:0]     cell_gt;
  ins_sort_pkg::cell_ctrl_t ctrl;

  logic s_accept, full, load_out;

  // control registers
  logic emit_q, emit_d;
  logic ovf_q, ovf_d;
  logic out_valid_q, out_valid_d;
  // output payload
  ins_sort_pkg::value_t out_key_q, out_key_d;
  logic out_last_q, out_last_d;
  logic out_ovf_q, out_ovf_d;

  assign key_in          = ins_sort_pkg::value_t'(s_axis_tdata_i);
  assign s_axis_tready_o = !emit_q;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = cell_valid[MAX_ITEMS-1];

  // drain one entry whenever the output register is free
  assign load_out = emit_q && (!out_valid_q || m_axis_tready_i);
  assign ctrl     = '{ins: s_accept && !full, shift: load_out};

  // the row of cells; cell 0 holds the smallest entry
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    ins_sort_pkg::value_t below_key, above_key;
    logic below_gt, below_valid, above_valid;

    if (i == 0) begin : g_bottom
      assign below_key   = key_in;
      assign below_gt    = 1'b0;
      assign below_valid = 1'b1;
    end else begin : g_mid_lo
      assign below_key   = cell_key[i-1];
      assign below_gt    = cell_gt[i-1];
      assign below_valid = cell_valid[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_top
      assign above_key   = cell_key[i];
      assign above_valid = 1'b0;
    end else begin : g_mid_hi
      assign above_key   = cell_key[i+1];
      assign above_valid = cell_valid[i+1];
    end

    ins_sort_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_i         (key_in),
      .below_key_i   (below_key),
      .below_gt_i    (below_gt),
      .below_valid_i (below_valid),
      .above_key_i   (above_key),
      .above_valid_i (above_valid),
      .key_o         (cell_key[i]),
      .valid_o       (cell_valid[i]),
      .gt_o          (cell_gt[i])
    );
  end

  always_comb begin
    emit_d      = emit_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_key_d   = out_key_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (s_accept) begin
      if (full) begin
        ovf_d = 1'b1;  // value dropped
      end
      if (s_axis_tlast_i) begin
        emit_d = 1'b1;
      end
    end

    if (load_out) begin
      out_valid_d = 1'b1;
      out_key_d   = cell_key[0];
      out_last_d  = !cell_valid[1];  // nothing left above cell 0
      out_ovf_d   = ovf_q;
      if (!cell_valid[1]) begin
        emit_d = 1'b0;
        ovf_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q      <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      emit_q      <= emit_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_key_q  <= out_key_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = 32'(out_key_q);
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ovf_q;

endmodule
`default_nettype wire

[rtl/ins_sort_chk.sv]
`default_nettype none
`include "insertion_sorter_assert.svh"
module ins_sort_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        s_axis_tlast_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic        m_axis_tlast_o,
  input wire logic        m_axis_tuser_o
);

  logic s_acc, m_acc;
  logic m_stall, s_close, m_mid, ovf_same;
  logic ovf_prev_q;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc    = m_axis_tvalid_o && m_axis_tready_i;
  assign m_stall  = m_axis_tvalid_o && !m_axis_tready_i;
  assign s_close  = s_acc && s_axis_tlast_i;
  assign m_mid    = m_acc && !m_axis_tlast_o;
  assign ovf_same = !m_axis_tvalid_o || (m_axis_tuser_o == ovf_prev_q);

  // flag as shown at the previous edge
  always_ff @(posedge clk_i) begin
    ovf_prev_q <= m_axis_tuser_o;
  end

  // a stalled result stays offered
  `INS_ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid_o, "result dropped while stalled")

  // a closing input starts draining, so input is held off
  `INS_ASSERT_NEXT(a_drain_blocks, s_close, !s_axis_tready_o, "input taken during drain")

  // overflow flag is the same on every result of a set
  `INS_ASSERT_NEXT(a_ovf_steady, m_mid, ovf_same, "overflow flag changed within set")

  // handshake outputs are never unknown out of reset
  `INS_ASSERT(a_known, !$isunknown({s_axis_tready_o, m_axis_tvalid_o}), "handshake unknown")

endmodule

bind insertion_sorter ins_sort_chk u_ins_sort_chk (.*);
`default_nettype wire

[bench/insertion_sorter_test.sv]
`default_nettype none
module insertion_sorter_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef ins_sort_pkg::value_t value_t;

  localparam int unsigned MaxItems    = 16;
  localparam int unsigned RandomItems = 175;
  localparam int unsigned IdlePct     = 16;   // chance of a gap per cycle, either side
  localparam int unsigned HoldCycles  = 120;  // long sink stall, forces the row to back up
  localparam int unsigned DrainTail   = 4 * MaxItems;

  // One expected output transaction.
  typedef struct packed {
    value_t value;
    logic   last_mark;
    logic   overflow_flag;
  } sorted_entry_t;

  // Keeps its own sorted row per set and the queue of results still owed.
  class sort_scoreboard;
    int unsigned   capacity;
    value_t        held[$];
    bit            dropped;
    sorted_entry_t owed[$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    int unsigned   sets_closed;
    int unsigned   overflow_sets;
    int unsigned   full_sets;

    function new(int unsigned cap);
      capacity = cap;
    endfunction

    // Accepted input: stable insert (after every entry <= v), or drop when full.
    function void note_input(value_t v, bit last_in);
      int unsigned pos;
      sorted_entry_t r;
      if (held.size() < capacity) begin
        pos = held.size();
        while (pos > 0 && held[pos-1] > v) pos--;
        held.insert(pos, v);
      end else begin
        dropped = 1'b1;
      end
      if (last_in) begin
        foreach (held[k]) begin
          r.value         = held[k];
          r.last_mark     = (k == held.size() - 1);
          r.overflow_flag = dropped;
          owed.push_back(r);
        end
        sets_closed++;
        if (dropped) overflow_sets++;
        if (held.size() == capacity) full_sets++;
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    task report(string what);
      $display("%0t ns  MISMATCH  %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(value_t v, bit last_out, bit ovf);
      sorted_entry_t want;
      results_seen++;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result value=%0d last=%0b ovf=%0b", v, last_out, ovf));
        return;
      end
      want = owed.pop_front();
      if (v !== want.value)
        report($sformatf("value %0d, want %0d", v, want.value));
      if (last_out !== want.last_mark)
        report($sformatf("tlast %0b, want %0b (value %0d)", last_out, want.last_mark, v));
      if (ovf !== want.overflow_flag)
        report($sformatf("overflow %0b, want %0b (value %0d)", ovf, want.overflow_flag, v));
    endtask

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [31:0] value
  logic        s_axis_tlast_i;   // last
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [31:0] value_res
  logic        m_axis_tlast_o;   // last_res
  logic        m_axis_tuser_o;   // [0] overflow

  insertion_sorter #(
    .MAX_ITEMS(MaxItems)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  sort_scoreboard sb = new(MaxItems);

  bit          steady;      // both sides run without gaps while set
  bit          hold_req;    // main asks the sink for one long stall
  int unsigned items_sent;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hard stop in case a handshake hangs.
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  // Monitor: both streams sampled at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_input(value_t'(s_axis_tdata_i), s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(value_t'(m_axis_tdata_o), m_axis_tlast_o, m_axis_tuser_o);
    end
  end

  // Sink: random back-pressure, plus one long stall on request counted here.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready_i <= steady || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // One input transaction; valid only changes at the falling edge.
  task automatic send_item(value_t v, bit last_in);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    s_axis_tlast_i  <= last_in;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  task automatic send_set(input value_t vals[$]);
    foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
  endtask

  // Sender stops and waits until the block owes nothing.
  task automatic pause_until_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic value_t rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return value_t'($urandom());
    if (pick < 75) return value_t'(int'($urandom_range(0, 7)) - 4);   // many ties
    if (pick < 85) return value_t'(32'h7fff_ffff - $urandom_range(0, 2));
    if (pick < 95) return value_t'(32'h8000_0000 + $urandom_range(0, 2));
    return value_t'(int'($urandom_range(0, 2000)) - 1000);
  endfunction

  function automatic int unsigned rand_set_len(int unsigned set_no);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (set_no == 5) return MaxItems;                              // exactly full
    if (pick < 70) return $urandom_range(1, 8);
    if (pick < 85) return $urandom_range(9, MaxItems);
    return $urandom_range(MaxItems + 1, MaxItems + 6);             // overflow
  endfunction

  initial begin
    value_t      vals[$];
    int unsigned set_no;
    int unsigned n;
    int unsigned random_start;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    steady          = 1'b0;
    hold_req        = 1'b0;
    items_sent      = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes with ties, a one-value set, and a set that
    // overflows with the tlast transaction itself being dropped.
    vals = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, -32'sd1, 32'sh7fff_ffff};
    send_set(vals);
    vals = '{32'sh8000_0000};
    send_set(vals);
    vals.delete();
    for (int k = 0; k < MaxItems + 1; k++) vals.push_back(value_t'(MaxItems - k));
    send_set(vals);
    pause_until_drained();

    // Random sets; a long sink stall early, a gap-free stretch, a full drain.
    random_start = items_sent;
    set_no = 0;
    while (items_sent - random_start < RandomItems) begin
      if (set_no == 2) hold_req = 1'b1;
      steady = (set_no >= 8 && set_no < 14);
      if (set_no == 16) pause_until_drained();
      n = rand_set_len(set_no);
      vals.delete();
      repeat (n) vals.push_back(rand_value());
      send_set(vals);
      set_no++;
    end
    steady = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);

    $display("covered %0d input transactions in %0d sets, %0d results checked",
             items_sent, sb.sets_closed, sb.results_seen);
    $display("%0d sets hit capacity, %0d of them dropped values; %0d mismatches",
             sb.full_sets, sb.overflow_sets, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
